// ----- rtl/core/tpht_pkg.sv -----
// ----------------------------------------------------------------------------
// tpht_pkg: shared types and constants
// Constants, queue entry type and back-end state codes for the threshold block.
// ----------------------------------------------------------------------------
package tpht_pkg;
  localparam int COUNT_BITS = 22;
  localparam int NBINS = 256;
  localparam int BIN_W = 8;
  localparam int Q_DEPTH = 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  // (255^2) * count: 16 + COUNT_BITS bits
  localparam int MEAS_W = 16 + COUNT_BITS;

  typedef struct packed {
    logic             req_type;
    logic [BIN_W-1:0] pixel_value;
    logic             last_pixel;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_CLR, ST_P1_RD, ST_P1, ST_P2_RD, ST_P2_MUL,
    ST_P2, ST_MN_RD, ST_MN, ST_EMIT
  } bstate_t;
endpackage

// ----- rtl/core/tpht_ram.sv -----
// ----------------------------------------------------------------------------
// tpht_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/core/tpht_queue.sv -----
// ----------------------------------------------------------------------------
// tpht_queue: front-end item queue
// Accepts input transfers and holds them until the back end takes them.
// ----------------------------------------------------------------------------
module tpht_queue import tpht_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);
  item_t            buf_r [Q_DEPTH];
  logic             rd_ptr_r, wr_ptr_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'(Q_DEPTH));
  assign empty = (cnt_r == 2'd0);
  assign head  = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end
endmodule

// ----- rtl/core/tpht_back.sv -----
// ----------------------------------------------------------------------------
// tpht_back: histogram and threshold engine
// Counts pixels, scans the histogram for peaks and valley, binarizes pixels.
// ----------------------------------------------------------------------------
module tpht_back import tpht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  item_t            q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_threshold,
  output logic [BIN_W-1:0] out_threshold_value,
  output logic             out_peaks_equal,
  output logic [BIN_W-1:0] out_binary_pixel
);
  bstate_t st_r, st_nxt;
  logic [BIN_W-1:0]      k_r, k_nxt;       // scan index
  logic [BIN_W-1:0]      p1_r, p1_nxt, p2_r, p2_nxt, mn_r, mn_nxt, hi_r, hi_nxt;
  logic [COUNT_BITS-1:0] best_c_r, best_c_nxt;
  logic [MEAS_W-1:0]     best_m_r, best_m_nxt, meas;
  logic [15:0]           dsq_r;
  logic [COUNT_BITS-1:0] cnt_hold_r;
  logic [BIN_W-1:0]      thr_r, thr_nxt;
  logic                  last_r, last_nxt;
  logic                  eq_r, eq_nxt;

  logic                  oval_r, oval_nxt, oist_r, oist_nxt, oeq_r, oeq_nxt;
  logic [BIN_W-1:0]      othr_r, othr_nxt, obin_r, obin_nxt;

  logic                  we;
  logic [BIN_W-1:0]      addr;
  logic [COUNT_BITS-1:0] wdata, rdata;
  logic [BIN_W-1:0]      bin_dist;

  tpht_ram #(.WIDTH(COUNT_BITS), .DEPTH(NBINS)) u_hist (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign out_valid           = oval_r;
  assign out_is_threshold    = oist_r;
  assign out_threshold_value = othr_r;
  assign out_peaks_equal     = oeq_r;
  assign out_binary_pixel    = obin_r;

  assign bin_dist = (k_r >= p1_r) ? (k_r - p1_r) : (p1_r - k_r);
  // dsq_r and cnt_hold_r both belong to bin k_r in ST_P2
  assign meas = MEAS_W'(dsq_r) * MEAS_W'(cnt_hold_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      k_r    <= '0;
      thr_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      k_r    <= k_nxt;
      thr_r  <= thr_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    mn_r     <= mn_nxt;
    hi_r     <= hi_nxt;
    best_c_r <= best_c_nxt;
    best_m_r <= best_m_nxt;
    last_r   <= last_nxt;
    eq_r     <= eq_nxt;
    oist_r   <= oist_nxt;
    othr_r   <= othr_nxt;
    oeq_r    <= oeq_nxt;
    obin_r   <= obin_nxt;
    dsq_r    <= 16'(bin_dist) * 16'(bin_dist);
    cnt_hold_r <= rdata;
  end

  always_comb begin
    st_nxt = st_r;  k_nxt = k_r;  thr_nxt = thr_r;
    p1_nxt = p1_r;  p2_nxt = p2_r; mn_nxt = mn_r; hi_nxt = hi_r;
    best_c_nxt = best_c_r; best_m_nxt = best_m_r; last_nxt = last_r;
    eq_nxt = eq_r;
    oval_nxt = oval_r && out_stall;
    oist_nxt = oist_r; othr_nxt = othr_r; oeq_nxt = oeq_r; obin_nxt = obin_r;
    q_pop = 1'b0;
    we = 1'b0;  addr = k_r;  wdata = '0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty && !oval_nxt) begin
          q_pop = 1'b1;
          if (q_head.req_type) begin
            oval_nxt = 1'b1;  oist_nxt = 1'b0;  othr_nxt = thr_r;  oeq_nxt = 1'b0;
            obin_nxt = (q_head.pixel_value > thr_r) ? 8'hFF : 8'h00;
          end else begin
            k_nxt = q_head.pixel_value;  last_nxt = q_head.last_pixel;
            st_nxt = ST_CNT_RD;
          end
        end
      end
      ST_CNT_RD: st_nxt = ST_CNT_WR;
      ST_CNT_WR: begin
        we = 1'b1;
        wdata = (rdata == COUNT_MAX) ? rdata : rdata + COUNT_BITS'(1);
        if (last_r) begin
          k_nxt = '0; st_nxt = ST_P1_RD;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        we = 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r == 8'hFF) st_nxt = ST_IDLE;
      end
      // first peak: read bin k, compare its count in the next cycle
      ST_P1_RD: begin
        best_c_nxt = '0; p1_nxt = '0;
        k_nxt = k_r + 1'b1; st_nxt = ST_P1;
      end
      ST_P1: begin
        if (rdata > best_c_r) begin
          best_c_nxt = rdata; p1_nxt = k_r - 1'b1;
        end
        if (k_r == 8'h00) begin
          best_m_nxt = '0; p2_nxt = '0;
          st_nxt = ST_P2_RD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // second peak, per bin: read, latch count, multiply and compare
      ST_P2_RD: st_nxt = ST_P2_MUL;
      ST_P2_MUL: st_nxt = ST_P2;
      ST_P2: begin
        if (meas > best_m_r) begin
          best_m_nxt = meas; p2_nxt = k_r;
        end
        if (k_r == 8'hFF) begin
          st_nxt = ST_MN_RD;
        end else begin
          k_nxt = k_r + 1'b1;
          st_nxt = ST_P2_RD;
        end
      end
      ST_MN_RD: begin
        if (p1_r == p2_r) begin
          thr_nxt = p1_r; eq_nxt = 1'b1; st_nxt = ST_EMIT;
        end else begin
          mn_nxt = (p1_r < p2_r) ? p1_r : p2_r;
          hi_nxt = (p1_r < p2_r) ? p2_r : p1_r;
          k_nxt  = (p1_r < p2_r) ? p1_r : p2_r;
          eq_nxt = 1'b0;
          st_nxt = ST_MN;
        end
      end
      ST_MN: begin
        // rdata holds bin k_r-1 once the scan has started
        if (k_r == mn_r) begin
          best_c_nxt = rdata; // discarded; value of lo arrives next cycle
          k_nxt = k_r + 1'b1;
        end else begin
          if (k_r - 1'b1 == mn_r) begin
            best_c_nxt = rdata;
          end else if (rdata < best_c_r) begin
            best_c_nxt = rdata; mn_nxt = k_r - 1'b1;
          end
          if (k_r == hi_r) begin
            thr_nxt = mn_nxt + 1'b1; st_nxt = ST_EMIT;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (!oval_nxt) begin
          oval_nxt = 1'b1; oist_nxt = 1'b1; othr_nxt = thr_r; obin_nxt = '0;
          oeq_nxt = eq_r;
          k_nxt = '0; st_nxt = ST_CLR;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/two_peak_histogram_threshold.sv -----
// ----------------------------------------------------------------------------
// two_peak_histogram_threshold: two-peak histogram threshold, 8-bit gray
// Flow: a binarize item passes the queue and the result register. A last count
// pixel starts the first-peak, second-peak and valley scans (no valley scan if
// the peaks are equal), emits the threshold and clears the histogram RAM before
// the next item is taken. Throughput: one binarize per cycle when idle and the
// output does not stall; a count (RAM read-modify-write) ends before the next item.
// Reset (sync) clears control and threshold, then the RAM before items are taken.
// ----------------------------------------------------------------------------
module two_peak_histogram_threshold import tpht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [BIN_W-1:0] in_pixel_value,
  input  logic             in_last_pixel,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_threshold,
  output logic [BIN_W-1:0] out_threshold_value,
  output logic             out_peaks_equal,
  output logic [BIN_W-1:0] out_binary_pixel
);
  item_t in_item, q_head;
  logic  q_full, q_empty, q_pop;

  // front: a transfer lands in the queue whenever there is room
  assign in_stall = q_full;
  assign in_item  = '{req_type: in_req_type, pixel_value: in_pixel_value,
                      last_pixel: in_last_pixel};

  tpht_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(in_valid && !q_full), .push_item(in_item),
    .full(q_full), .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  // back: histogram RAM, peak/valley scans and result register
  tpht_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_threshold(out_is_threshold), .out_threshold_value(out_threshold_value),
    .out_peaks_equal(out_peaks_equal), .out_binary_pixel(out_binary_pixel)
  );
endmodule
